[rtl/pfdla_pkg.sv]
// Package for the pose frame deframer: widths, constants, the CORDIC table
// and the float to fixed conversion helper. No dependencies.
package pfdla_pkg;

    localparam int FRAME_LEN     = 28;
    localparam int BURST_MAX_DEF = 99;
    localparam int CNT_W         = 7;
    localparam int LEVER_W       = 10;
    localparam logic [LEVER_W-1:0] LEVER_RESET = 10'd160;
    localparam int CORDIC_STEPS  = 16;
    localparam int STEP_W        = 4;

    localparam logic signed [39:0] MM_MAXMAG  = 40'sd549755813887;
    localparam logic signed [39:0] ANG_MAXMAG = 40'sd33554431;
    localparam logic signed [31:0] DEG90      = 32'sd5898240;
    localparam logic signed [31:0] DEG180     = 32'sd11796480;
    localparam logic signed [31:0] DEG360     = 32'sd23592960;
    localparam logic signed [39:0] CORDIC_K   = 40'sd652032874;

    localparam logic [7:0] BYTE_CR = 8'h0D;
    localparam logic [7:0] BYTE_LF = 8'h0A;

    typedef enum logic {
        OP_DATA = 1'b0,
        OP_IDLE = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_REDUCE,
        ST_ROTATE,
        ST_SCALE,
        ST_SUM,
        ST_OUT
    } state_t;

    // Control from the sequencer to the shared rotation unit.
    typedef struct packed {
        logic             load;
        logic             step;
        logic [STEP_W-1:0] idx;
    } rot_ctl_t;

    function automatic logic signed [31:0] atan_q16(input logic [STEP_W-1:0] i);
        logic signed [31:0] r;
        begin
            case (i)
                4'd0:  r = 32'sd2949120;
                4'd1:  r = 32'sd1740967;
                4'd2:  r = 32'sd919879;
                4'd3:  r = 32'sd466945;
                4'd4:  r = 32'sd234379;
                4'd5:  r = 32'sd117304;
                4'd6:  r = 32'sd58666;
                4'd7:  r = 32'sd29335;
                4'd8:  r = 32'sd14668;
                4'd9:  r = 32'sd7334;
                4'd10: r = 32'sd3667;
                4'd11: r = 32'sd1833;
                4'd12: r = 32'sd917;
                4'd13: r = 32'sd458;
                4'd14: r = 32'sd229;
                default: r = 32'sd115;
            endcase
            return r;
        end
    endfunction

    // Float to signed fixed point with frac fraction bits; bit 40 flags clamping.
    function automatic logic [40:0] float_to_fix(input logic [31:0] w,
                                                 input logic [4:0] frac,
                                                 input logic [39:0] maxmag);
        logic        neg;
        logic [7:0]  ex;
        logic [23:0] man;
        logic [40:0] limit;
        logic [40:0] mag;
        logic signed [9:0] sh;
        logic        sat;
        logic signed [40:0] res;
        begin
            neg   = w[31];
            ex    = w[30:23];
            man   = {1'b0, w[22:0]};
            limit = {1'b0, maxmag} + {40'd0, neg};
            sat   = 1'b0;
            mag   = 41'd0;
            if (ex == 8'hFF) begin
                sat = 1'b1;
                mag = (w[22:0] != 0) ? 41'd0 : limit;
            end else begin
                if (ex != 8'd0) begin
                    man[23] = 1'b1;
                end else begin
                    ex = 8'd1;
                end
                sh = $signed({2'b00, ex}) - 10'sd150 + $signed({5'd0, frac});
                if (man == 24'd0) begin
                    mag = 41'd0;
                end else if (sh >= 0) begin
                    if (sh > 10'sd17) begin
                        mag = limit + 41'd1;
                    end else begin
                        mag = {17'd0, man} << sh[4:0];
                    end
                end else if (-sh >= 10'sd32) begin
                    mag = 41'd0;
                end else begin
                    mag = {17'd0, man} >> 5'(-sh);
                end
                if (mag > limit) begin
                    sat = 1'b1;
                    mag = limit;
                end
            end
            res = neg ? -$signed(mag) : $signed(mag);
            return {sat, res[39:0]};
        end
    endfunction

endpackage

[rtl/pfdla_deframer.sv]
// Byte window and frame matcher of the pose frame deframer.
// Depends on pfdla_pkg.
module pfdla_deframer #(
    parameter int BURST_MAX = pfdla_pkg::BURST_MAX_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      byte_en,
    input  logic [7:0]                byte_in,
    input  logic                      burst_clr,
    output logic                      burst_nonempty,
    output logic [31:0]               angle_word,
    output logic [31:0]               pos_x_word,
    output logic [31:0]               pos_y_word
);
    import pfdla_pkg::*;

    logic [7:0]       win_reg [FRAME_LEN];
    logic [7:0]       win_next [FRAME_LEN];
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [31:0]      ang_reg, px_reg, py_reg;
    logic             take, hit;

    assign take = byte_en && (cnt_reg < CNT_W'(BURST_MAX));

    always_comb begin
        for (int i = 0; i < FRAME_LEN - 1; i++) begin
            win_next[i] = win_reg[i+1];
        end
        win_next[FRAME_LEN-1] = byte_in;
        cnt_next = cnt_reg + 1'b1;
        hit = (cnt_next >= CNT_W'(FRAME_LEN)) && win_next[0] == BYTE_CR &&
              win_next[1] == BYTE_LF && win_next[26] == BYTE_LF &&
              win_next[27] == BYTE_CR;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            ang_reg <= '0;
            px_reg  <= '0;
            py_reg  <= '0;
            for (int i = 0; i < FRAME_LEN; i++) begin
                win_reg[i] <= '0;
            end
        end else if (burst_clr) begin
            cnt_reg <= '0;
        end else if (take) begin
            win_reg <= win_next;
            cnt_reg <= cnt_next;
            if (hit) begin
                ang_reg <= {win_next[5], win_next[4], win_next[3], win_next[2]};
                px_reg  <= {win_next[17], win_next[16], win_next[15], win_next[14]};
                py_reg  <= {win_next[21], win_next[20], win_next[19], win_next[18]};
            end
        end
    end

    assign burst_nonempty = (cnt_reg != '0);
    assign angle_word     = ang_reg;
    assign pos_x_word     = px_reg;
    assign pos_y_word     = py_reg;
endmodule

[rtl/pfdla_cordic.sv]
// Shared CORDIC rotation unit: one micro-rotation per cycle on its registers while ctl.step is set.
// Depends on pfdla_pkg.
module pfdla_cordic (
    input  logic                   aclk,
    input  pfdla_pkg::rot_ctl_t    ctl,
    input  logic signed [31:0]     angle_in,
    output logic signed [39:0]     sin_out,
    output logic signed [39:0]     cos_out
);
    import pfdla_pkg::*;

    logic signed [39:0] x_reg, y_reg;
    logic signed [31:0] z_reg;
    logic signed [39:0] xs, ys;

    assign xs = x_reg >>> ctl.idx;
    assign ys = y_reg >>> ctl.idx;

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            x_reg <= CORDIC_K;
            y_reg <= '0;
            z_reg <= angle_in;
        end else if (ctl.step) begin
            if (z_reg >= 0) begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - atan_q16(ctl.idx);
            end else begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + atan_q16(ctl.idx);
            end
        end
    end

    assign sin_out = y_reg;
    assign cos_out = x_reg;
endmodule

[rtl/pose_frame_deframer_lever_arm.sv]
// Pose frame deframer with lever-arm correction.
//
// Input stream s_*: tdata[7:0] = data_byte, tuser[0] = opcode (0 byte, 1 idle).
// Data bytes are taken back to back while no solve is in flight and slide through a 28-byte window;
// a frame 0D 0A <24 bytes> 0A 0D found inside the current burst latches the
// angle, X and Y words. An idle word after a non-empty burst starts the
// position solve; an idle word after an empty burst is simply dropped.
// Config port cfg_*: cfg_data is the lever arm in mm, written when valid and
// ready are high; taken only when no solve is in flight.
// Output m_*: tdata = {saturated, angle_centideg, pos_y_mm, pos_x_mm} with
// pos_x_mm at bit 0, padded to 104 bits. One word per non-empty burst.
// A solve runs from the idle word to m_tvalid through conversion, reduction,
// 16 CORDIC steps on the one shared rotation unit, scaling, sum and output.
// s_tready is low from the idle word until the result is taken, so a stalled
// receiver holds the result and the input with it.
// Reset (aresetn low, synchronous) clears the window, the stored words, the
// burst count and sets the lever arm to 160 mm.
module pose_frame_deframer_lever_arm #(
    parameter int BURST_MAX = pfdla_pkg::BURST_MAX_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] data_byte
    input  logic         s_tuser,   // [0] opcode
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [pfdla_pkg::LEVER_W-1:0] cfg_data,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata    // pos_x_mm, pos_y_mm, angle_centideg, saturated
);
    import pfdla_pkg::*;

    state_t state_reg, state_next;
    logic [STEP_W-1:0]  idx_reg, idx_next;
    logic [LEVER_W-1:0] lever_reg;
    rot_ctl_t           ctl;
    logic               burst_nonempty, s_fire, burst_clr;
    logic [31:0]        ang_w, px_w, py_w;
    logic signed [39:0] ang_reg, px_reg, py_reg, lx_reg, ly_reg;
    logic signed [31:0] red_v;
    logic               flip_v;
    logic               flip_reg, sat_reg;
    logic signed [39:0] sin_v, cos_v;
    logic [40:0]        fa, fx, fy;
    logic signed [31:0] ra;
    logic signed [63:0] ra_full;
    logic signed [39:0] sx, cx;
    logic signed [49:0] ml_s, ml_c;
    logic signed [41:0] sum_x, sum_y;
    logic               clip_x_reg, clip_y_reg;
    logic [31:0]        ox_reg, oy_reg, oa_reg;
    logic               osat;

    assign s_fire    = s_tvalid && s_tready;
    assign burst_clr = s_fire && s_tuser == OP_IDLE;

    pfdla_deframer #(.BURST_MAX(BURST_MAX)) u_deframer (
        .aclk(aclk), .aresetn(aresetn),
        .byte_en(s_fire && s_tuser == OP_DATA), .byte_in(s_tdata),
        .burst_clr(burst_clr), .burst_nonempty(burst_nonempty),
        .angle_word(ang_w), .pos_x_word(px_w), .pos_y_word(py_w)
    );

    pfdla_cordic u_cordic (
        .aclk(aclk), .ctl(ctl), .angle_in(red_v),
        .sin_out(sin_v), .cos_out(cos_v)
    );

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        case (state_reg)
            ST_IDLE:   if (burst_clr && burst_nonempty) state_next = ST_CONV;
            ST_CONV:   state_next = ST_REDUCE;
            ST_REDUCE: begin
                state_next = ST_ROTATE;
                idx_next   = '0;
            end
            ST_ROTATE: begin
                idx_next = idx_reg + 1'b1;
                if (idx_reg == STEP_W'(CORDIC_STEPS - 1)) state_next = ST_SCALE;
            end
            ST_SCALE:  state_next = ST_SUM;
            ST_SUM:    state_next = ST_OUT;
            ST_OUT:    if (m_tready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready  = (state_reg == ST_IDLE);
        cfg_ready = (state_reg == ST_IDLE);
        m_tvalid  = (state_reg == ST_OUT);
        ctl.load  = (state_reg == ST_REDUCE);
        ctl.step  = (state_reg == ST_ROTATE);
        ctl.idx   = idx_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            lever_reg <= LEVER_RESET;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            if (cfg_valid && cfg_ready) lever_reg <= cfg_data;
        end
    end

    assign fa = float_to_fix(ang_w, 5'd16, ANG_MAXMAG);
    assign fx = float_to_fix(px_w, 5'd8, MM_MAXMAG);
    assign fy = float_to_fix(py_w, 5'd8, MM_MAXMAG);

    // Angle magnitude is at most 512 degrees, so two folds of 360 suffice.
    always_comb begin
        ra = ang_reg[31:0];
        if (ra >= DEG180) ra = ra - DEG360;
        if (ra >= DEG180) ra = ra - DEG360;
        if (ra < -DEG180) ra = ra + DEG360;
        if (ra < -DEG180) ra = ra + DEG360;
    end

    // The folded angle goes straight into the rotation unit as it loads.
    always_comb begin
        if (ra > DEG90) begin
            red_v  = ra - DEG180;
            flip_v = 1'b1;
        end else if (ra < -DEG90) begin
            red_v  = ra + DEG180;
            flip_v = 1'b1;
        end else begin
            red_v  = ra;
            flip_v = 1'b0;
        end
    end

    assign sx   = flip_reg ? -sin_v : sin_v;
    assign cx   = flip_reg ? -cos_v : cos_v;
    assign ml_s = $signed({1'b0, lever_reg}) * $signed(sx[38:0]);
    assign ml_c = $signed({1'b0, lever_reg}) * $signed(cx[38:0]);

    assign sum_x = 42'(px_reg) + 42'(lx_reg);
    assign sum_y = 42'(py_reg) + 42'($signed({1'b0, lever_reg, 8'd0})) - 42'(ly_reg);

    function automatic logic [32:0] q8_sat(input logic signed [41:0] v);
        logic signed [41:0] m;
        logic signed [33:0] r;
        begin
            m = v < 0 ? -v : v;
            r = v < 0 ? -$signed({1'b0, m[40:8]}) : $signed({1'b0, m[40:8]});
            if (r > 34'sd2147483647) return {1'b1, 32'h7FFFFFFF};
            if (r < -34'sd2147483648) return {1'b1, 32'h80000000};
            return {1'b0, r[31:0]};
        end
    endfunction

    assign ra_full = 64'(ang_reg) * 64'sd100;

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_CONV: begin
                ang_reg <= $signed(fa[39:0]);
                px_reg  <= $signed(fx[39:0]);
                py_reg  <= $signed(fy[39:0]);
                sat_reg <= fa[40] | fx[40] | fy[40];
                oa_reg  <= '0;
            end
            ST_REDUCE: begin
                flip_reg <= flip_v;
                oa_reg <= ra_full < 0 ? 32'(-((-ra_full) >>> 16)) : 32'(ra_full >>> 16);
            end
            ST_SCALE: begin
                lx_reg <= 40'(ml_s >>> 22);
                ly_reg <= 40'(ml_c >>> 22);
            end
            ST_SUM: begin
                {clip_x_reg, ox_reg} <= q8_sat(sum_x);
                {clip_y_reg, oy_reg} <= q8_sat(sum_y);
            end
            default: ;
        endcase
    end

    assign osat = sat_reg | clip_x_reg | clip_y_reg;

    assign m_tdata = {7'd0, osat, oa_reg, oy_reg, ox_reg};

    // After the sum state a valid result word always follows.
    property p_out_after_rotate;
        @(posedge aclk) disable iff (!aresetn)
            (state_reg == ST_SUM) |=> m_tvalid;
    endproperty
    assert property (p_out_after_rotate) else $error("result did not follow sum");

    property p_no_input_while_busy;
        @(posedge aclk) disable iff (!aresetn)
            (state_reg != ST_IDLE) |-> !s_tready && !cfg_ready;
    endproperty
    assert property (p_no_input_while_busy) else $error("input taken while busy");

    property p_result_held;
        @(posedge aclk) disable iff (!aresetn)
            (m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata);
    endproperty
    assert property (p_result_held) else $error("stalled result changed");
endmodule

[test/pose_solution_checker.sv]
// Checker for the pose frame deframer: watches the byte, config and result
// channels, predicts each position report and compares it field by field.
// Depends on pfdla_pkg for the opcode enum, the byte markers and the widths.
`timescale 1ns / 100ps

module pose_solution_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [7:0]   s_tdata,
    input  logic         s_tuser,
    input  logic         cfg_valid,
    input  logic         cfg_ready,
    input  logic [pfdla_pkg::LEVER_W-1:0] cfg_data,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [103:0] m_tdata,
    output int           fail_count,
    output int           reports_pending
);
    import pfdla_pkg::*;

    typedef struct {
        logic signed [31:0] x_mm;
        logic signed [31:0] y_mm;
        logic signed [31:0] heading_cdeg;
        logic               clamped;
    } pose_report_t;

    localparam int BURST_LIMIT = BURST_MAX_DEF;

    pose_report_t report_q[$];
    logic [7:0]   window[FRAME_LEN];
    int           burst_bytes;
    logic [31:0]  heading_bits, x_bits, y_bits;
    logic [LEVER_W-1:0] arm_mm;

    const longint rot_angles[16] = '{2949120, 1740967, 919879, 466945, 234379,
        117304, 58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115};

    assign reports_pending = report_q.size();

    function automatic longint fix_from_float(input logic [31:0] w, input int frac,
                                              input longint maxmag, inout bit clamp);
        bit neg = w[31];
        int ex = w[30:23];
        longint unsigned man = w[22:0];
        longint unsigned lim = maxmag + neg;
        longint unsigned mag;
        int sh;
        if (ex == 255) begin
            clamp = 1;
            if (man != 0) return 0;
            mag = lim;
        end else begin
            if (ex != 0) man |= 64'h800000;
            else ex = 1;
            sh = ex - 150 + frac;
            if (man == 0) mag = 0;
            else if (sh >= 0) mag = (sh > 40) ? lim + 1 : (man << sh);
            else mag = (-sh >= 32) ? 0 : (man >> (-sh));
            if (mag > lim) begin
                clamp = 1;
                mag = lim;
            end
        end
        return neg ? -longint'(mag) : longint'(mag);
    endfunction

    function automatic longint mm_to_int(input longint v, inout bit clamp);
        longint r = (v < 0) ? -((-v) >>> 8) : (v >>> 8);
        if (r > 64'sd2147483647) begin
            clamp = 1;
            r = 64'sd2147483647;
        end else if (r < -64'sd2147483648) begin
            clamp = 1;
            r = -64'sd2147483648;
        end
        return r;
    endfunction

    function automatic pose_report_t solve_pose();
        pose_report_t rep;
        bit clamp = 0;
        bit flip = 0;
        longint ang, px, py, a, cx, cy, t, lx, ly, arm, ra;
        ang = fix_from_float(heading_bits, 16, 64'd33554431, clamp);
        px = fix_from_float(x_bits, 8, 64'd549755813887, clamp);
        py = fix_from_float(y_bits, 8, 64'd549755813887, clamp);
        a = ang;
        while (a >= 11796480) a -= 23592960;
        while (a < -11796480) a += 23592960;
        if (a > 5898240) begin
            a -= 11796480;
            flip = 1;
        end else if (a < -5898240) begin
            a += 11796480;
            flip = 1;
        end
        cx = 652032874;
        cy = 0;
        for (int i = 0; i < 16; i++) begin
            if (a >= 0) begin
                t = cx - (cy >>> i);
                cy = cy + (cx >>> i);
                a -= rot_angles[i];
            end else begin
                t = cx + (cy >>> i);
                cy = cy - (cx >>> i);
                a += rot_angles[i];
            end
            cx = t;
        end
        if (flip) begin
            cx = -cx;
            cy = -cy;
        end
        arm = arm_mm;
        lx = (arm * cy) >>> 22;
        ly = (arm * cx) >>> 22;
        rep.x_mm = 32'(mm_to_int(px + lx, clamp));
        rep.y_mm = 32'(mm_to_int(py + arm * 256 - ly, clamp));
        ra = ang * 100;
        ra = (ra < 0) ? -((-ra) >>> 16) : (ra >>> 16);
        rep.heading_cdeg = 32'(ra);
        rep.clamped = clamp;
        return rep;
    endfunction

    always @(posedge aclk) begin
        pose_report_t want;
        logic [103:0] got;
        if (!aresetn) begin
            foreach (window[i]) window[i] = 8'h00;
            burst_bytes = 0;
            heading_bits = 0;
            x_bits = 0;
            y_bits = 0;
            arm_mm = LEVER_RESET;
            fail_count = 0;
            report_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) arm_mm = cfg_data;
            if (s_tvalid && s_tready) begin
                if (op_t'(s_tuser) == OP_DATA) begin
                    if (burst_bytes < BURST_LIMIT) begin
                        for (int i = 0; i < FRAME_LEN - 1; i++) window[i] = window[i+1];
                        window[FRAME_LEN-1] = s_tdata;
                        burst_bytes++;
                        if (burst_bytes >= FRAME_LEN && window[0] == BYTE_CR &&
                            window[1] == BYTE_LF && window[26] == BYTE_LF &&
                            window[27] == BYTE_CR) begin
                            heading_bits = {window[5], window[4], window[3], window[2]};
                            x_bits = {window[17], window[16], window[15], window[14]};
                            y_bits = {window[21], window[20], window[19], window[18]};
                        end
                    end
                end else if (burst_bytes != 0) begin
                    burst_bytes = 0;
                    report_q.push_back(solve_pose());
                end
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (report_q.size() == 0) begin
                    $error("result word with no report expected");
                    fail_count++;
                end else begin
                    want = report_q.pop_front();
                    if (got[31:0] !== want.x_mm) begin
                        $error("pos_x_mm expected %0d got %0d", want.x_mm, $signed(got[31:0]));
                        fail_count++;
                    end
                    if (got[63:32] !== want.y_mm) begin
                        $error("pos_y_mm expected %0d got %0d", want.y_mm, $signed(got[63:32]));
                        fail_count++;
                    end
                    if (got[95:64] !== want.heading_cdeg) begin
                        $error("angle_centideg expected %0d got %0d", want.heading_cdeg,
                               $signed(got[95:64]));
                        fail_count++;
                    end
                    if (got[96] !== want.clamped) begin
                        $error("saturated expected %0d got %0d", want.clamped, got[96]);
                        fail_count++;
                    end
                end
            end
        end
    end

endmodule

[test/testbench.sv]
// Top of the pose frame deframer test: clock, reset, byte bursts with frames,
// lever arm writes, receiver stalls and the verdict.
// Depends on pfdla_pkg, the block and pose_solution_checker.
`timescale 1ns / 100ps

module testbench;
    import pfdla_pkg::*;

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [7:0]   s_tdata = 0;
    logic         s_tuser = 0;
    logic         cfg_valid = 0;
    logic         cfg_ready;
    logic [LEVER_W-1:0] cfg_data = 0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [103:0] m_tdata;
    int           fail_count;
    int           reports_pending;
    int           words_sent = 0;
    bit           no_gaps = 0;

    always #5 aclk = ~aclk;

    pose_frame_deframer_lever_arm DUT (.*);

    pose_solution_checker checker_inst (.*);

    initial begin
        #20ms;
        $display("Regression FAIL");
        $finish;
    end

    // Receiver: random stall before each result word, none while no_gaps is set.
    always begin
        @(posedge aclk);
        if (aresetn) begin
            if (!no_gaps) begin
                m_tready <= 0;
                repeat ($urandom_range(0, 19)) @(posedge aclk);
            end
            m_tready <= 1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    task automatic send_word(input op_t op, input logic [7:0] b);
        int gap = no_gaps ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            s_tvalid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tuser <= op;
        s_tdata <= b;
        do @(posedge aclk); while (!s_tready);
        words_sent++;
    endtask

    task automatic end_burst();
        send_word(OP_IDLE, 8'($urandom));
    endtask

    function automatic logic [31:0] random_float(input bit heading);
        logic [31:0] w = $urandom;
        case ($urandom_range(0, 15))
            0: w = 32'h7FC00000 | ($urandom & 32'h803FFFFF);
            1: w = {w[31], 8'hFF, 23'd0};
            2: w = {w[31], 8'h00, w[22:0]};
            3: w = {w[31], 31'd0};
            4: ;
            default: w[30:23] = heading ? 8'($urandom_range(115, 136))
                                        : 8'($urandom_range(110, 165));
        endcase
        return w;
    endfunction

    task automatic send_frame(input logic [31:0] hd, input logic [31:0] xw,
                              input logic [31:0] yw, input bit spoil);
        logic [7:0] f[28];
        logic [31:0] words[6];
        words = '{hd, $urandom, $urandom, xw, yw, $urandom};
        f[0] = BYTE_CR;
        f[1] = BYTE_LF;
        for (int n = 0; n < 6; n++)
            for (int k = 0; k < 4; k++) f[2 + 4*n + k] = words[n][8*k +: 8];
        f[26] = BYTE_LF;
        f[27] = BYTE_CR;
        if (spoil) f[$urandom_range(0, 1) ? $urandom_range(0, 1) : $urandom_range(26, 27)] ^= 8'h01;
        foreach (f[i]) send_word(OP_DATA, f[i]);
    endtask

    task automatic random_burst();
        int kind = $urandom_range(0, 19);
        if (kind == 0) begin
            end_burst();
        end else if (kind == 1) begin
            // Over-long burst: the frame lands past the byte limit and is dropped.
            repeat ($urandom_range(72, 100)) send_word(OP_DATA, 8'($urandom));
            send_frame(random_float(1), random_float(0), random_float(0), 0);
            end_burst();
        end else if (kind == 2) begin
            // Frame split across two bursts must not be recognized.
            send_word(OP_DATA, BYTE_CR);
            send_word(OP_DATA, BYTE_LF);
            repeat (10) send_word(OP_DATA, 8'($urandom));
            end_burst();
            repeat (14) send_word(OP_DATA, 8'($urandom));
            send_word(OP_DATA, BYTE_LF);
            send_word(OP_DATA, BYTE_CR);
            end_burst();
        end else if (kind < 5) begin
            repeat ($urandom_range(1, 40)) send_word(OP_DATA, 8'($urandom));
            end_burst();
        end else begin
            repeat ($urandom_range(0, 8)) send_word(OP_DATA, 8'($urandom));
            send_frame(random_float(1), random_float(0), random_float(0), kind == 5);
            if ($urandom_range(0, 3) == 0)
                send_frame(random_float(1), random_float(0), random_float(0), 0);
            repeat ($urandom_range(0, 6)) send_word(OP_DATA, 8'($urandom));
            end_burst();
        end
    endtask

    task automatic set_lever_arm(input logic [LEVER_W-1:0] v);
        s_tvalid <= 0;
        @(posedge aclk);
        wait (reports_pending == 0);
        repeat (30) @(posedge aclk);
        cfg_valid <= 1;
        cfg_data <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 0;
    endtask

    initial begin
        logic [LEVER_W-1:0] arms[6];
        arms = '{10'd0, 10'd1023, 10'd1000, 10'd1, 10'd160, 10'd0};
        arms[5] = LEVER_W'($urandom_range(0, 1023));
        repeat (9) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed: empty burst, byte extremes, NaN/infinite/denormal words.
        end_burst();
        send_word(OP_DATA, 8'h00);
        send_word(OP_DATA, 8'hFF);
        end_burst();
        send_frame(32'h7FC00000, 32'h7F800000, 32'h00000001, 0);
        end_burst();
        send_frame(32'hC3FA0000, 32'hFF800000, 32'h80000000, 0);
        end_burst();

        for (int ph = 0; ph < 6; ph++) begin
            set_lever_arm(arms[ph]);
            no_gaps = (ph == 3);
            while (words_sent < 250 * (ph + 1)) random_burst();
        end
        no_gaps = 0;
        s_tvalid <= 0;
        @(posedge aclk);
        wait (reports_pending == 0);
        repeat (40) @(posedge aclk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/pfdla_pkg.sv
rtl/pfdla_deframer.sv
rtl/pfdla_cordic.sv
rtl/pose_frame_deframer_lever_arm.sv
test/pose_solution_checker.sv
test/testbench.sv
